// File: hw/rtl/octt_pkg.sv
`default_nettype none

package octt_pkg;

  // span and lag settings of the oscillator
  localparam int LONG_SPAN  = 34;
  localparam int SHORT_SPAN = 5;
  localparam int LAG_STEP   = 7;
  localparam int PRICE_BITS = 24;

  // derived widths
  localparam int MID_W     = PRICE_BITS + 1;
  localparam int LSUM_W    = MID_W + $clog2(LONG_SPAN + 1);
  localparam int SSUM_W    = MID_W + $clog2(SHORT_SPAN + 1);
  localparam int OSC_W     = LSUM_W + $clog2(SHORT_SPAN + 1) + 2;
  localparam int GAIN_W    = 7;
  localparam int COEF_W    = GAIN_W + 1;
  localparam int PROD_W    = OSC_W + COEF_W;
  localparam int D_W       = PROD_W + 2;
  localparam int PROFIT_W  = 40;
  localparam int TALLY_W   = 20;
  localparam int NUM_GAINS = 4;
  localparam int CFG_IDX_W = 2;
  localparam int PPTR_W    = $clog2(LONG_SPAN);
  localparam int PCNT_W    = $clog2(LONG_SPAN + 1);
  localparam int OPTR_W    = (LAG_STEP > 1) ? $clog2(LAG_STEP) : 1;
  localparam int OCNT_W    = $clog2(LAG_STEP + 1);

  // coefficient is this base minus the gain setting
  localparam int GAIN_BASE = 100;

  localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

  // register indexes of the config port
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_NOW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_LAG7  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_LAG14 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_LAG21 = 2'd3;

  // signal sign codes
  localparam logic [1:0] SIGN_ZERO = 2'd0;
  localparam logic [1:0] SIGN_POS  = 2'd1;
  localparam logic [1:0] SIGN_NEG  = 2'd2;

  typedef struct packed {
    logic [PRICE_BITS-1:0] bar_high;
    logic [PRICE_BITS-1:0] bar_low;
    logic [PRICE_BITS-1:0] bar_open;
    logic [PRICE_BITS-1:0] bar_close;
    logic                  in_window;
    logic                  window_end;
  } bar_t;

  typedef struct packed {
    logic                       opened;
    logic                       closed;
    logic [1:0]                 signal_sign;
    logic signed [PROFIT_W-1:0] running_profit;
    logic [TALLY_W-1:0]         deals_done;
  } res_t;

  // bar fields that the trade logic still needs
  typedef struct packed {
    logic [PRICE_BITS-1:0] bar_open;
    logic [PRICE_BITS-1:0] bar_close;
    logic                  in_window;
    logic                  window_end;
  } trade_t;

  // request from the running-sum stage to the signal stages
  typedef struct packed {
    logic                    valid;
    logic signed [OSC_W-1:0] osc;
    trade_t                  trade;
  } osc_req_t;

  // one history entry: oscillator one, two and three lag steps apart
  typedef struct packed {
    logic signed [OSC_W-1:0] lag_a;
    logic signed [OSC_W-1:0] lag_b;
    logic signed [OSC_W-1:0] lag_c;
  } hist_t;

endpackage

`default_nettype wire

// File: hw/rtl/oscillator_crossing_trade_tracker_unit.sv
// channel | direction | handshake          | payload
// --------+-----------+--------------------+-----------------------------
// in      | input     | in_valid, in_stall | in_bar  (bar_t)
// out     | output    | out_valid, out_stall | out_res (res_t)
// cfg     | input     | cfg_wr_en          | cfg_index, cfg_data (gain)
//
// one bar is taken every cycle while in_stall is low; its result is registered in turn
// through the price ring read, the running sums, the history ring read, the multiply,
// the add and the trade stages.
// rst_n is synchronous; it clears the rings' fill counts, sums, position and
// tallies, and sets every gain to 100.
// out_stall holds the whole pipe; in_stall is high only while a result waits.
`default_nettype none

module oscillator_crossing_trade_tracker_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  octt_pkg::bar_t                 in_bar,
  output logic                           out_valid,
  input  logic                           out_stall,
  output octt_pkg::res_t                 out_res,
  input  logic                           cfg_wr_en,
  input  logic [octt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [octt_pkg::GAIN_W-1:0]    cfg_data
);
  import octt_pkg::*;

  logic                     adv;
  logic                     bar_take;
  osc_req_t                 osc_req;
  logic                     osc_take;
  logic signed [COEF_W-1:0] coef_r [NUM_GAINS];
  logic [COEF_W-1:0]        coef_wr;
  hist_t                    hist_mem [LAG_STEP];
  hist_t                    hist_rd_r;
  hist_t                    fwd_data_r;
  logic                     fwd_r;
  hist_t                    hist_cur;
  hist_t                    hist_wdata;
  logic                     hist_wr;
  logic [OPTR_W-1:0]        optr_r;
  logic [OPTR_W-1:0]        optr_nxt;
  logic [OCNT_W-1:0]        ocnt_r;
  logic [OCNT_W-1:0]        ocnt_nxt;
  logic                     t1_vld_r;
  logic signed [OSC_W-1:0]  t1_osc_r;
  logic                     t1_ok_r;
  logic [OPTR_W-1:0]        t1_addr_r;
  trade_t                   t1_trade_r;
  logic signed [PROD_W-1:0] prod_nxt [NUM_GAINS];
  logic signed [PROD_W-1:0] prod_r [NUM_GAINS];
  logic                     t2_vld_r;
  trade_t                   t2_trade_r;
  logic signed [D_W-1:0]    d_sum;
  logic                     t3_vld_r;
  logic                     t3_pos_r;
  logic                     t3_neg_r;
  trade_t                   t3_trade_r;
  logic                     trd_fire;
  logic                     op_do;
  logic                     hold_mid;
  logic                     cl_do;
  logic                     win_clear;
  logic                     holding_r;
  logic                     holding_nxt;
  logic [PROFIT_W-1:0]      profit_r;
  logic [PROFIT_W-1:0]      profit_nxt;
  logic [TALLY_W-1:0]       tally_r;
  logic [TALLY_W-1:0]       tally_nxt;
  logic [1:0]               sign_code;
  logic                     out_valid_r;
  res_t                     out_res_r;

  // the pipe moves whenever the output register is empty or its result is being taken
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;
  assign bar_take = in_valid && adv;

  // gain registers, kept as signed coefficients
  assign coef_wr = COEF_W'(GAIN_BASE) - COEF_W'(cfg_data);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_GAINS; k++) begin
        coef_r[k] <= '0;
      end
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_GAIN_NOW:   coef_r[0] <= coef_wr;
        REG_GAIN_LAG7:  coef_r[1] <= coef_wr;
        REG_GAIN_LAG14: coef_r[2] <= coef_wr;
        REG_GAIN_LAG21: coef_r[3] <= coef_wr;
        default: ;
      endcase
    end
  end

  // price ring and running sums
  octt_sum_stage u_sum (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .bar_take (bar_take),
    .bar      (in_bar),
    .osc_req  (osc_req)
  );

  // history ring pointers
  assign osc_take = adv && osc_req.valid;
  assign optr_nxt = (optr_r == OPTR_W'(LAG_STEP - 1)) ? '0 : optr_r + 1'b1;
  assign ocnt_nxt = (ocnt_r == OCNT_W'(LAG_STEP)) ? ocnt_r : ocnt_r + 1'b1;
  assign hist_wr  = adv && t1_vld_r;

  // history entry for this bar; forward a write to the slot being read
  assign hist_cur = !t1_ok_r ? '0 : (fwd_r ? fwd_data_r : hist_rd_r);
  assign hist_wdata.lag_a = t1_osc_r;
  assign hist_wdata.lag_b = hist_cur.lag_a;
  assign hist_wdata.lag_c = hist_cur.lag_b;

  always_ff @(posedge clk) begin
    if (hist_wr) begin
      hist_mem[t1_addr_r] <= hist_wdata;
    end
    if (osc_take) begin
      hist_rd_r  <= hist_mem[optr_r];
      fwd_r      <= hist_wr && (t1_addr_r == optr_r);
      fwd_data_r <= hist_wdata;
    end
  end

  // weighted terms
  assign prod_nxt[0] = PROD_W'(coef_r[0]) * PROD_W'(t1_osc_r);
  assign prod_nxt[1] = PROD_W'(coef_r[1]) * PROD_W'(hist_cur.lag_a);
  assign prod_nxt[2] = PROD_W'(coef_r[2]) * PROD_W'(hist_cur.lag_b);
  assign prod_nxt[3] = PROD_W'(coef_r[3]) * PROD_W'(hist_cur.lag_c);

  // signal sum
  assign d_sum = D_W'(prod_r[0]) + D_W'(prod_r[1]) + D_W'(prod_r[2]) + D_W'(prod_r[3]);

  // trade decisions
  assign trd_fire  = adv && t3_vld_r;
  assign op_do     = t3_trade_r.in_window && !holding_r && t3_pos_r;
  assign hold_mid  = holding_r || op_do;
  assign cl_do     = t3_trade_r.in_window && hold_mid && (t3_neg_r || t3_trade_r.window_end);
  assign win_clear = t3_trade_r.in_window && t3_trade_r.window_end;

  always_comb begin
    profit_nxt = profit_r;
    if (op_do) begin
      profit_nxt = profit_nxt - PROFIT_W'(t3_trade_r.bar_open);
    end
    if (cl_do) begin
      profit_nxt = profit_nxt + PROFIT_W'(t3_trade_r.bar_close);
    end
  end

  assign tally_nxt   = (op_do && (tally_r != TALLY_MAX)) ? tally_r + 1'b1 : tally_r;
  assign holding_nxt = hold_mid && !cl_do;
  assign sign_code   = t3_pos_r ? SIGN_POS : (t3_neg_r ? SIGN_NEG : SIGN_ZERO);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      optr_r      <= '0;
      ocnt_r      <= '0;
      t1_vld_r    <= 1'b0;
      t2_vld_r    <= 1'b0;
      t3_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      holding_r   <= 1'b0;
      profit_r    <= '0;
      tally_r     <= '0;
    end else begin
      if (osc_take) begin
        optr_r <= optr_nxt;
        ocnt_r <= ocnt_nxt;
      end
      if (adv) begin
        t1_vld_r    <= osc_req.valid;
        t2_vld_r    <= t1_vld_r;
        t3_vld_r    <= t2_vld_r;
        out_valid_r <= t3_vld_r;
      end
      if (trd_fire) begin
        holding_r <= holding_nxt;
        profit_r  <= win_clear ? '0 : profit_nxt;
        tally_r   <= win_clear ? '0 : tally_nxt;
      end
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (osc_take) begin
      t1_osc_r   <= osc_req.osc;
      t1_ok_r    <= (ocnt_r == OCNT_W'(LAG_STEP));
      t1_addr_r  <= optr_r;
      t1_trade_r <= osc_req.trade;
    end
    if (adv && t1_vld_r) begin
      for (int k = 0; k < NUM_GAINS; k++) begin
        prod_r[k] <= prod_nxt[k];
      end
      t2_trade_r <= t1_trade_r;
    end
    if (adv && t2_vld_r) begin
      t3_pos_r   <= !d_sum[D_W-1] && (d_sum != '0);
      t3_neg_r   <= d_sum[D_W-1];
      t3_trade_r <= t2_trade_r;
    end
    if (trd_fire) begin
      out_res_r.opened         <= op_do;
      out_res_r.closed         <= cl_do;
      out_res_r.signal_sign    <= sign_code;
      out_res_r.running_profit <= profit_nxt;
      out_res_r.deals_done     <= tally_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

`ifndef SYNTHESIS
  // window end leaves profit and tally cleared
  a_window_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (trd_fire && win_clear) |=> (profit_r == '0 && tally_r == '0))
    else $error("profit or tally not cleared after window end");

  // forced close leaves no open position
  a_window_flat: assert property (@(posedge clk) disable iff (!rst_n)
    (trd_fire && win_clear) |=> !holding_r)
    else $error("position still held after window end");

  // history fill count stays within the ring
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r <= OCNT_W'(LAG_STEP))
    else $error("history fill count beyond ring depth");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/octt_sum_stage.sv
`default_nettype none

module octt_sum_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              bar_take,
  input  octt_pkg::bar_t    bar,
  output octt_pkg::osc_req_t osc_req
);
  import octt_pkg::*;

  logic [MID_W-1:0]        price_mem [LONG_SPAN];
  logic [PPTR_W-1:0]       pptr_r;
  logic [PPTR_W-1:0]       pptr_nxt;
  logic [PPTR_W-1:0]       sh_addr;
  logic [PCNT_W-1:0]       pcnt_r;
  logic [PCNT_W-1:0]       pcnt_nxt;
  logic [MID_W-1:0]        mid2;
  logic [MID_W-1:0]        sh_rd_r;
  logic [MID_W-1:0]        lg_rd_r;
  logic [MID_W-1:0]        sh_old;
  logic [MID_W-1:0]        lg_old;
  logic                    s1_vld_r;
  logic [MID_W-1:0]        s1_mid_r;
  logic                    s1_sh_ok_r;
  logic                    s1_lg_ok_r;
  trade_t                  s1_trade_r;
  logic [LSUM_W-1:0]       long_sum_r;
  logic [LSUM_W-1:0]       long_sum_nxt;
  logic [SSUM_W-1:0]       short_sum_r;
  logic [SSUM_W-1:0]       short_sum_nxt;
  logic [OSC_W-1:0]        osc_nxt;
  logic                    osc_vld_r;
  logic signed [OSC_W-1:0] osc_val_r;
  trade_t                  osc_trade_r;

  // midpoint sum and ring pointers
  assign mid2     = MID_W'(bar.bar_high) + MID_W'(bar.bar_low);
  assign pptr_nxt = (pptr_r == PPTR_W'(LONG_SPAN - 1)) ? '0 : pptr_r + 1'b1;
  assign pcnt_nxt = (pcnt_r == PCNT_W'(LONG_SPAN)) ? pcnt_r : pcnt_r + 1'b1;
  assign sh_addr  = (pptr_r >= PPTR_W'(SHORT_SPAN)) ? pptr_r - PPTR_W'(SHORT_SPAN)
                                                    : pptr_r + PPTR_W'(LONG_SPAN - SHORT_SPAN);

  // price ring: new midpoint in, short and long tails out
  always_ff @(posedge clk) begin
    if (bar_take) begin
      price_mem[pptr_r] <= mid2;
      sh_rd_r           <= price_mem[sh_addr];
      lg_rd_r           <= price_mem[pptr_r];
    end
  end

  // tails not yet written count as zero
  assign sh_old = s1_sh_ok_r ? sh_rd_r : '0;
  assign lg_old = s1_lg_ok_r ? lg_rd_r : '0;

  // running sums and oscillator from sums before this bar
  assign long_sum_nxt  = long_sum_r + LSUM_W'(s1_mid_r) - LSUM_W'(lg_old);
  assign short_sum_nxt = short_sum_r + SSUM_W'(s1_mid_r) - SSUM_W'(sh_old);
  assign osc_nxt = OSC_W'(SHORT_SPAN) * OSC_W'(long_sum_r)
                 - OSC_W'(LONG_SPAN) * OSC_W'(short_sum_r);

  // control and sum state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pptr_r      <= '0;
      pcnt_r      <= '0;
      s1_vld_r    <= 1'b0;
      osc_vld_r   <= 1'b0;
      long_sum_r  <= '0;
      short_sum_r <= '0;
    end else begin
      if (bar_take) begin
        pptr_r <= pptr_nxt;
        pcnt_r <= pcnt_nxt;
      end
      if (adv) begin
        s1_vld_r  <= bar_take;
        osc_vld_r <= s1_vld_r;
      end
      if (adv && s1_vld_r) begin
        long_sum_r  <= long_sum_nxt;
        short_sum_r <= short_sum_nxt;
      end
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (bar_take) begin
      s1_mid_r             <= mid2;
      s1_sh_ok_r           <= (pcnt_r >= PCNT_W'(SHORT_SPAN));
      s1_lg_ok_r           <= (pcnt_r == PCNT_W'(LONG_SPAN));
      s1_trade_r.bar_open   <= bar.bar_open;
      s1_trade_r.bar_close  <= bar.bar_close;
      s1_trade_r.in_window  <= bar.in_window;
      s1_trade_r.window_end <= bar.window_end;
    end
    if (adv && s1_vld_r) begin
      osc_val_r   <= osc_nxt;
      osc_trade_r <= s1_trade_r;
    end
  end

  assign osc_req.valid = osc_vld_r;
  assign osc_req.osc   = osc_val_r;
  assign osc_req.trade = osc_trade_r;

endmodule

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import octt_pkg::*;

  localparam int HIST_DEPTH    = 3 * LAG_STEP;
  localparam int PRICE_MAX     = (1 << PRICE_BITS) - 1;
  localparam logic [PRICE_BITS-1:0] PRICE_TOP = '1;
  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 12;
  localparam logic [CFG_IDX_W-1:0] GAIN_REGS [NUM_GAINS] =
    '{REG_GAIN_NOW, REG_GAIN_LAG7, REG_GAIN_LAG14, REG_GAIN_LAG21};

  typedef enum int {PACE_FULL, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_t;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  bar_t                 in_bar    = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  res_t                 out_res;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [GAIN_W-1:0]    cfg_data  = '0;

  pace_t pace         = PACE_FULL;
  int    hold_left    = 0;
  int    quiet_cycles = 0;
  int    fail_count   = 0;
  int    bars_sent    = 0;
  int    results_seen = 0;
  int    opens_seen   = 0;
  int    closes_seen  = 0;

  // shadow copy of the tracker state
  logic [GAIN_W-1:0]   gain_shadow [NUM_GAINS];
  logic [MID_W-1:0]    mid_line [LONG_SPAN];
  longint              long_acc;
  longint              short_acc;
  longint              osc_past [HIST_DEPTH];
  bit                  in_position;
  logic [PROFIT_W-1:0] pnl;
  logic [TALLY_W-1:0]  deal_count;
  res_t                outcomes_due [$];

  oscillator_crossing_trade_tracker_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_bar    (in_bar),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // signed weight of one oscillator tap
  function automatic longint weight(input int k);
    return longint'(GAIN_BASE) - longint'(gain_shadow[k]);
  endfunction

  task automatic reset_shadow();
    int k;
    for (k = 0; k < NUM_GAINS; k++) gain_shadow[k] = GAIN_W'(GAIN_BASE);
    for (k = 0; k < LONG_SPAN; k++) mid_line[k] = '0;
    for (k = 0; k < HIST_DEPTH; k++) osc_past[k] = 0;
    long_acc    = 0;
    short_acc   = 0;
    in_position = 1'b0;
    pnl         = '0;
    deal_count  = '0;
  endtask

  // trade outcome of one bar, advancing the shadow state
  function automatic res_t bar_outcome(input bar_t bar);
    res_t             r;
    logic [MID_W-1:0] mid;
    longint           osc;
    longint           drive;
    int               k;
    mid   = MID_W'(bar.bar_high) + MID_W'(bar.bar_low);
    osc   = SHORT_SPAN * long_acc - LONG_SPAN * short_acc;
    drive = weight(0) * osc + weight(1) * osc_past[LAG_STEP-1]
          + weight(2) * osc_past[2*LAG_STEP-1] + weight(3) * osc_past[3*LAG_STEP-1];
    r = '0;
    r.signal_sign = (drive > 0) ? SIGN_POS : (drive < 0) ? SIGN_NEG : SIGN_ZERO;
    if (bar.in_window) begin
      if (!in_position && drive > 0) begin
        pnl = pnl - PROFIT_W'(bar.bar_open);
        if (deal_count != TALLY_MAX) deal_count = deal_count + 1'b1;
        in_position = 1'b1;
        r.opened    = 1'b1;
      end
      if (in_position && (drive < 0 || bar.window_end)) begin
        pnl = pnl + PROFIT_W'(bar.bar_close);
        in_position = 1'b0;
        r.closed    = 1'b1;
      end
    end
    r.running_profit = pnl;
    r.deals_done     = deal_count;
    if (bar.in_window && bar.window_end) begin
      pnl        = '0;
      deal_count = '0;
    end
    // oscillator history, then price line and running sums
    for (k = HIST_DEPTH - 1; k > 0; k--) osc_past[k] = osc_past[k-1];
    osc_past[0] = osc;
    long_acc  = long_acc - longint'(mid_line[LONG_SPAN-1]);
    short_acc = short_acc - longint'(mid_line[SHORT_SPAN-1]);
    for (k = LONG_SPAN - 1; k > 0; k--) mid_line[k] = mid_line[k-1];
    mid_line[0] = mid;
    long_acc  = long_acc + longint'(mid);
    short_acc = short_acc + longint'(mid);
    return r;
  endfunction

  function automatic bar_t flat_bar(input logic [PRICE_BITS-1:0] price, input bit win,
                                    input bit wend);
    bar_t b;
    b.bar_high   = price;
    b.bar_low    = price;
    b.bar_open   = price;
    b.bar_close  = price;
    b.in_window  = win;
    b.window_end = wend;
    return b;
  endfunction

  function automatic bar_t market_bar(input int mid, input int spread, input bit win,
                                      input bit wend);
    bar_t b;
    int   hi;
    int   lo;
    hi = (mid + spread > PRICE_MAX) ? PRICE_MAX : mid + spread;
    lo = (mid - spread < 0) ? 0 : mid - spread;
    b.bar_high   = PRICE_BITS'(hi);
    b.bar_low    = PRICE_BITS'(lo);
    b.bar_open   = PRICE_BITS'($urandom_range(hi, lo));
    b.bar_close  = PRICE_BITS'($urandom_range(hi, lo));
    b.in_window  = win;
    b.window_end = wend;
    return b;
  endfunction

  // send one request and wait until the block takes it
  task automatic send_bar(input bar_t bar);
    int idle_pct;
    idle_pct = (pace == PACE_SEND_IDLE) ? 47 : (pace == PACE_BOTH) ? 9 : 0;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_bar   <= bar;
    do @(posedge clk); while (in_stall);
    outcomes_due.push_back(bar_outcome(bar));
    bars_sent++;
  endtask

  // stop offering, let every result come back, then let the pipe settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_gains(input logic [GAIN_W-1:0] g_now, input logic [GAIN_W-1:0] g_7,
                             input logic [GAIN_W-1:0] g_14, input logic [GAIN_W-1:0] g_21);
    logic [GAIN_W-1:0] vals [NUM_GAINS];
    int                k;
    vals = '{g_now, g_7, g_14, g_21};
    for (k = 0; k < NUM_GAINS; k++) begin
      cfg_wr_en      <= 1'b1;
      cfg_index      <= GAIN_REGS[k];
      cfg_data       <= vals[k];
      gain_shadow[k]  = vals[k];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  // market-like bars: trading windows over a random walk, with some pure noise
  task automatic run_market(input int n_bars);
    bar_t b;
    int   left;
    int   gap;
    int   span;
    int   mid;
    int   vol;
    int   k;
    left = n_bars;
    mid  = $urandom_range(PRICE_MAX);
    while (left > 0) begin
      if ($urandom_range(99) < 12) begin
        b.bar_high   = PRICE_BITS'($urandom());
        b.bar_low    = PRICE_BITS'($urandom());
        b.bar_open   = PRICE_BITS'($urandom());
        b.bar_close  = PRICE_BITS'($urandom());
        b.in_window  = 1'($urandom_range(1));
        b.window_end = 1'($urandom_range(1));
        send_bar(b);
        left--;
      end else begin
        gap  = $urandom_range(4);
        span = $urandom_range(40, 3);
        vol  = 1 << $urandom_range(20, 4);
        if ($urandom_range(9) == 0) mid = $urandom_range(PRICE_MAX);
        for (k = 0; k < gap + span; k++) begin
          mid = mid + int'($urandom_range(2 * vol)) - vol;
          if (mid < 0) mid = 0;
          if (mid > PRICE_MAX) mid = PRICE_MAX;
          send_bar(market_bar(mid, $urandom_range(vol), k >= gap, k == gap + span - 1));
          left--;
        end
      end
    end
  endtask

  // gains at reset give zero weights: no trade, whatever the bars
  task automatic test_reset_defaults();
    send_bar(flat_bar(PRICE_TOP, 1'b1, 1'b0));
    send_bar(flat_bar('0, 1'b1, 1'b0));
    send_bar(flat_bar(PRICE_TOP, 1'b1, 1'b1));
    send_bar(flat_bar('0, 1'b0, 1'b1));
    wait_idle();
  endtask

  // opens, closes, forced close and window handling with only the current tap
  task automatic test_trade_cases();
    bar_t b;
    int   k;
    write_gains(7'd0, 7'd100, 7'd100, 7'd100);
    // rising bars push the oscillator negative, nothing held so nothing closes
    repeat (2) send_bar(flat_bar(PRICE_TOP, 1'b1, 1'b0));
    // flat bottom drains the short sum, signal turns positive and opens
    for (k = 0; k < 6; k++) begin
      b = flat_bar('0, 1'b1, 1'b0);
      b.bar_open  = PRICE_TOP;
      b.bar_close = PRICE_TOP;
      send_bar(b);
    end
    // window end outside the window is ignored, position stays held
    send_bar(flat_bar(PRICE_TOP, 1'b0, 1'b1));
    // jump up, negative signal closes
    repeat (3) send_bar(flat_bar(PRICE_TOP, 1'b1, 1'b0));
    // reopen on the bottom, then forced close at window end
    repeat (5) send_bar(flat_bar('0, 1'b1, 1'b0));
    send_bar(flat_bar('0, 1'b1, 1'b1));
    // open and forced close on the same bar
    send_bar(flat_bar('0, 1'b1, 1'b1));
    wait_idle();
  endtask

  task automatic test_market_phase(input pace_t mode, input logic [GAIN_W-1:0] g_now,
                                   input logic [GAIN_W-1:0] g_7,
                                   input logic [GAIN_W-1:0] g_14,
                                   input logic [GAIN_W-1:0] g_21, input int n_bars);
    write_gains(g_now, g_7, g_14, g_21);
    pace = mode;
    run_market(n_bars);
    wait_idle();
  endtask

  // long output hold while bars keep coming, so the pipe fills and stalls its input
  task automatic test_backpressure();
    write_gains(7'd20, 7'd80, 7'd110, 7'd100);
    pace      = PACE_FULL;
    hold_left = 200;
    run_market(60);
    wait_idle();
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) <
                    ((pace == PACE_RECV_STALL) ? 47 : (pace == PACE_BOTH) ? 9 : 0));
    end
  end

  task automatic check_field(input string name, input logic signed [63:0] want_v,
                             input logic signed [63:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      fail_count++;
    end
  endtask

  // compare each returned request with the oldest expectation
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (outcomes_due.size() == 0) begin
        $error("result with nothing expected: %p", out_res);
        fail_count++;
      end else begin
        want = outcomes_due.pop_front();
        results_seen++;
        if (out_res.opened === 1'b1) opens_seen++;
        if (out_res.closed === 1'b1) closes_seen++;
        check_field("opened", 64'(want.opened), 64'(out_res.opened));
        check_field("closed", 64'(want.closed), 64'(out_res.closed));
        check_field("signal_sign", 64'(want.signal_sign), 64'(out_res.signal_sign));
        check_field("running_profit", 64'(want.running_profit),
                    64'(out_res.running_profit));
        check_field("deals_done", 64'(want.deals_done), 64'(out_res.deals_done));
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // test sequence
  initial begin
    reset_shadow();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_trade_cases();
    test_market_phase(PACE_FULL, 7'd0, 7'd100, 7'd100, 7'd100, 170);
    test_market_phase(PACE_SEND_IDLE, 7'd0, 7'd0, 7'd0, 7'd0, 170);
    test_market_phase(PACE_RECV_STALL, 7'd127, 7'd1, 7'd64, 7'd100, 170);
    test_market_phase(PACE_BOTH, 7'd1, 7'd127, 7'd0, 7'd50, 170);
    test_market_phase(PACE_BOTH, GAIN_W'($urandom_range(127)), GAIN_W'($urandom_range(127)),
                      GAIN_W'($urandom_range(127)), GAIN_W'($urandom_range(127)), 170);
    test_backpressure();
    $display("sent %0d bars, checked %0d results, saw %0d opens and %0d closes",
             bars_sent, results_seen, opens_seen, closes_seen);
    $display("gains swept 0 to 127 under four pacing modes plus one long output hold");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
